@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the semaphore block.
// Clock and reset are passed in; every assertion is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/csq_pkg.sv @@
// Package for the counting semaphore with wait queue: payload types,
// request and status codes, default sizes. Depends on nothing.
`default_nettype none

package csq_pkg;

    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int THREAD_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [1:0] OP_DOWN     = 2'd0;
    localparam logic [1:0] OP_TRY_DOWN = 2'd1;
    localparam logic [1:0] OP_UP       = 2'd2;

    localparam logic [2:0] ST_ACQUIRED   = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_TRY_FAILED = 3'd2;
    localparam logic [2:0] ST_RAISED     = 3'd3;
    localparam logic [2:0] ST_WOKEN      = 3'd4;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd5;
    localparam logic [2:0] ST_AT_LIMIT   = 3'd6;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] caller_thread;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  woken_thread;
        logic [15:0] count_now;
    } rsp_t;

endpackage

`default_nettype wire

@@ design/csq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/counting_semaphore_wait_queue_top.sv @@
// Counting semaphore with a FIFO queue of blocked thread numbers.
// Uses csq_pkg and csq_ram (waiter store).
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_t: op, caller_thread
//  rsp     | out       | rsp_valid/rsp_stall | rsp_t: status, woken_thread, count_now
//  cfg     | in        | cfg_valid/cfg_ready | initial count, 16 bits
//
// One request per cycle unless req_stall is high. Responses pass the middle stage
// and output register; the registered waiter store read needs the middle stage.
// Reset leaves count zero and the queue empty; no clearing pass is needed.
// A stalled response holds the pipeline; requests stall only when both the
// middle stage and the output register are full.
`default_nettype none

module counting_semaphore_wait_queue_top
    import csq_pkg::*;
#(
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    parameter int THREAD_BITS = THREAD_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_initial_count
);

    localparam int PTR_W   = $clog2(WAIT_DEPTH);
    localparam int TOTAL_W = $clog2(WAIT_DEPTH + 1);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [2:0]            s1_status_reg, s1_status_next;
    logic                  s1_pop_reg, s1_pop_next;
    logic [15:0]           s1_count_reg, s1_count_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  s1_move;
    logic                  push;
    logic                  pop;
    logic [THREAD_BITS-1:0] caller;
    logic [THREAD_BITS-1:0] ram_rdata;

    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign caller    = THREAD_BITS'(req.caller_thread);

    csq_ram #(
        .WIDTH (THREAD_BITS),
        .DEPTH (WAIT_DEPTH)
    ) u_waiters (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (caller),
        .re    (pop),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        push           = 1'b0;
        pop            = 1'b0;
        s1_status_next = s1_status_reg;
        s1_pop_next    = s1_pop_reg;

        if (accept)
        begin
            s1_status_next = ST_TRY_FAILED;
            s1_pop_next    = 1'b0;
            unique case (req.op)
                OP_DOWN:
                begin
                    if (count_reg != '0)
                    begin
                        count_next     = count_reg - COUNT_BITS'(1);
                        s1_status_next = ST_ACQUIRED;
                    end
                    else if (total_reg == TOTAL_W'(WAIT_DEPTH))
                    begin
                        s1_status_next = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        push           = 1'b1;
                        tail_next      = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                         '0 : tail_reg + PTR_W'(1);
                        total_next     = total_reg + TOTAL_W'(1);
                        s1_status_next = ST_QUEUED;
                    end
                end
                OP_TRY_DOWN:
                begin
                    if (count_reg != '0)
                    begin
                        count_next     = count_reg - COUNT_BITS'(1);
                        s1_status_next = ST_ACQUIRED;
                    end
                end
                OP_UP:
                begin
                    if (total_reg != '0)
                    begin
                        pop            = 1'b1;
                        head_next      = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                         '0 : head_reg + PTR_W'(1);
                        total_next     = total_reg - TOTAL_W'(1);
                        s1_status_next = ST_WOKEN;
                        s1_pop_next    = 1'b1;
                    end
                    else if (count_reg == '1)
                    begin
                        s1_status_next = ST_AT_LIMIT;
                    end
                    else
                    begin
                        count_next     = count_reg + COUNT_BITS'(1);
                        s1_status_next = ST_RAISED;
                    end
                end
                default:
                begin
                    s1_status_next = ST_TRY_FAILED;
                end
            endcase
        end

        // reload count and drop all waiters
        if (cfg_valid && cfg_ready)
        begin
            count_next = COUNT_BITS'(cfg_initial_count);
            head_next  = '0;
            tail_next  = '0;
            total_next = '0;
        end
    end

    always_comb
    begin
        s1_count_next = accept ? 16'(count_next) : s1_count_reg;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        rsp_next = rsp_reg;
        if (s1_move)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = s1_status_reg;
            rsp_next.woken_thread = s1_pop_reg ? 8'(ram_rdata) : 8'd0;
            rsp_next.count_now    = s1_count_reg;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_pop_reg    <= s1_pop_next;
        s1_count_reg  <= s1_count_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

@@ design/csq_checker.sv @@
// Port-level checks for the semaphore block, bound to its top level.
// Depends on csq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module csq_checker
    import csq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire rsp_t        rsp
);

    `CSQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid,
                     "response dropped while stalled")
    `CSQ_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp),
                     "stalled response changed")
    `CSQ_ASSERT_NOW(a_status_code, clk, rst_n, rsp_valid, rsp.status <= ST_AT_LIMIT,
                    "undefined status code")
    `CSQ_ASSERT_NOW(a_woken_zero, clk, rst_n, rsp_valid && (rsp.status != ST_WOKEN),
                    rsp.woken_thread == 8'd0, "woken thread without wake")
    // request side backs up only behind a stalled response
    `CSQ_ASSERT_NOW(a_req_stall_cause, clk, rst_n, req_stall, rsp_valid && rsp_stall,
                    "request stalled with output free")

endmodule

bind counting_semaphore_wait_queue_top csq_checker u_csq_checker (.*);

`default_nettype wire

@@ test/tb_counting_semaphore_wait_queue_top.sv @@
// Self-checking testbench for counting_semaphore_wait_queue_top: directed and random
// down, try-down, up and reserved-op requests checked against an in-bench semaphore predictor.
// Depends on csq_pkg and the block's RTL only.
`default_nettype none

module tb_counting_semaphore_wait_queue_top;
    import csq_pkg::*;

    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_in = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_initial_count = '0;

    // predictor state
    logic [15:0] units_left = '0;
    logic [7:0]  blocked_threads[$];
    rsp_t        pending_results[$];

    int  error_count = 0;
    int  hold_cycles = 0;
    bit  idling_on = 1'b1;
    int  quiet_cycles = 0;

    counting_semaphore_wait_queue_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req               (req_in),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .rsp               (rsp_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_initial_count (cfg_initial_count)
    );

    always #2 clk = ~clk;

    // Apply one request to the predicted semaphore and return its response.
    function automatic rsp_t next_semaphore_result(input req_t r);
        rsp_t res;
        res.status       = ST_TRY_FAILED;
        res.woken_thread = '0;
        case (r.op)
            OP_DOWN:
            begin
                if (units_left != 0)
                begin
                    units_left--;
                    res.status = ST_ACQUIRED;
                end
                else if (blocked_threads.size() >= WAIT_DEPTH_DEF)
                    res.status = ST_QUEUE_FULL;
                else
                begin
                    blocked_threads.push_back(r.caller_thread);
                    res.status = ST_QUEUED;
                end
            end
            OP_TRY_DOWN:
            begin
                if (units_left != 0)
                begin
                    units_left--;
                    res.status = ST_ACQUIRED;
                end
            end
            OP_UP:
            begin
                if (blocked_threads.size() != 0)
                begin
                    res.woken_thread = blocked_threads.pop_front();
                    res.status = ST_WOKEN;
                end
                else if (units_left == COUNT_MAX)
                    res.status = ST_AT_LIMIT;
                else
                begin
                    units_left++;
                    res.status = ST_RAISED;
                end
            end
            default: ;
        endcase
        res.count_now = units_left;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_request(input logic [1:0] op, input logic [7:0] thread);
        req_t item;
        item.op = op;
        item.caller_thread = thread;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 99) < 33)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_in = item;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(next_semaphore_result(item));
    endtask

    // Stop offering and wait for every predicted response plus the pipeline depth.
    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_initial_count = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        units_left = value;
        blocked_threads.delete();
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [1:0] pick_op(input bit up_heavy);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return OP_RESERVED;
        if (roll < 20)
            return OP_TRY_DOWN;
        if (up_heavy)
            return (roll < 40) ? OP_DOWN : OP_UP;
        return (roll < 70) ? OP_DOWN : OP_UP;
    endfunction

    // Alternate down-heavy and up-heavy stretches so the queue fills and drains.
    task automatic run_random_requests(input int n_items);
        bit up_heavy;
        up_heavy = $urandom_range(0, 1);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 24 == 0 && i != 0)
                up_heavy = ~up_heavy;
            send_request(pick_op(up_heavy), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_reset_state();
        send_request(OP_TRY_DOWN, 8'h00);
    endtask

    task automatic test_acquire_paths();
        write_initial_count(16'd2);
        send_request(OP_DOWN, 8'h00);
        send_request(OP_TRY_DOWN, 8'hFF);
        send_request(OP_TRY_DOWN, 8'h5A);
        send_request(OP_RESERVED, 8'hA5);
    endtask

    // Count is zero here: fill the wait queue, overflow it, then wake in order.
    task automatic test_queue_full();
        send_request(OP_DOWN, 8'h00);
        send_request(OP_DOWN, 8'hFF);
        for (int i = 2; i < WAIT_DEPTH_DEF; i++)
            send_request(OP_DOWN, 8'(i * 17));
        send_request(OP_DOWN, 8'h77);
        send_request(OP_UP, 8'h00);
        send_request(OP_UP, 8'hFF);
    endtask

    // Loading the count also clears the waiters left by the previous test.
    task automatic test_count_limit();
        write_initial_count(COUNT_MAX);
        send_request(OP_UP, 8'h12);
        send_request(OP_DOWN, 8'h34);
    endtask

    task automatic test_backpressure();
        write_initial_count(16'd3);
        idling_on = 1'b0;
        hold_cycles = 60;
        run_random_requests(40);
        idling_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_random_requests(10);
        drain_results();
        run_random_requests(10);
    endtask

    task automatic test_random_mix();
        logic [15:0] start_counts[6];
        start_counts = '{16'd0, COUNT_MAX, 16'd1, 16'($urandom_range(0, 65535)),
                         16'hFFFE, 16'($urandom_range(0, 8))};
        foreach (start_counts[k])
        begin
            write_initial_count(start_counts[k]);
            // one phase runs with no idling on either side
            idling_on = (k != 3);
            run_random_requests(80);
        end
        idling_on = 1'b1;
    endtask

    // receiver stall: long hold-off when requested, random while idling is on, none otherwise
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (idling_on)
            rsp_stall <= ($urandom_range(0, 99) < 33);
        else
            rsp_stall <= 1'b0;
    end

    // compare each response transaction with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected response, status", rsp_out.status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_out.status !== want.status)
                    report_mismatch("status", rsp_out.status, want.status);
                if (rsp_out.woken_thread !== want.woken_thread)
                    report_mismatch("woken_thread", rsp_out.woken_thread, want.woken_thread);
                if (rsp_out.count_now !== want.count_now)
                    report_mismatch("count_now", rsp_out.count_now, want.count_now);
            end
        end
    end

    // end the run when no transaction moves for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_acquire_paths();
        test_queue_full();
        test_count_limit();
        test_backpressure();
        test_sender_pause();
        test_random_mix();

        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
